// ===== sv/epq_pkg.sv =====
// Shared constants, widths and the arctangent table of the pose converter.
package epq_pkg;

    // Default number of rotation steps in each sine/cosine pipeline.
    localparam int CORDIC_STEPS_DEF = 18;
    localparam int ATAN_LEN         = 24;

    // Field widths.
    localparam int POS_W = 32;
    localparam int DEG_W = 26;
    localparam int RAD_W = 20;
    localparam int Q_W   = 18;

    // Datapath width of the rotation pipeline (Q.30 values and headroom).
    localparam int CW = 33;

    // Angle scaling constants.
    localparam logic signed [DEG_W-1:0] DEG_LIMIT = 26'sd23592960;
    localparam logic [26:0]             DEG2RAD_Q32 = 27'd74961321;

    // Half-angle range reduction constants in Q.30.
    localparam logic signed [CW-1:0] PI_Q30     = 33'sd3373259426;
    localparam logic signed [CW-1:0] HALFPI_Q30 = 33'sd1686629713;
    localparam logic signed [CW-1:0] GAIN_Q30   = 33'sh026DD3B6A;

    // Quaternion saturation limit in Q1.16.
    localparam logic signed [Q_W-1:0] Q16_ONE = 18'sd65536;

    // Arctangent of 2^-i in Q.30.
    function automatic logic signed [CW-1:0] atan_q30(input logic [4:0] idx);
        logic signed [CW-1:0] val;
        unique case (idx)
            5'd0:    val = 33'sh03243F6A8;
            5'd1:    val = 33'sh01DAC6705;
            5'd2:    val = 33'sh00FADBAFC;
            5'd3:    val = 33'sh007F56EA6;
            5'd4:    val = 33'sh003FEAB76;
            5'd5:    val = 33'sh001FFD55B;
            5'd6:    val = 33'sh000FFFAAA;
            5'd7:    val = 33'sh0007FFF55;
            5'd8:    val = 33'sh0003FFFEA;
            5'd9:    val = 33'sh0001FFFFD;
            5'd10:   val = 33'sh0000FFFFF;
            5'd11:   val = 33'sh00007FFFF;
            5'd12:   val = 33'sh00003FFFF;
            5'd13:   val = 33'sh00001FFFF;
            5'd14:   val = 33'sh00000FFFF;
            5'd15:   val = 33'sh000007FFF;
            5'd16:   val = 33'sh000003FFF;
            5'd17:   val = 33'sh000001FFF;
            5'd18:   val = 33'sh000000FFF;
            5'd19:   val = 33'sh0000007FF;
            5'd20:   val = 33'sh0000003FF;
            5'd21:   val = 33'sh0000001FF;
            5'd22:   val = 33'sh0000000FF;
            5'd23:   val = 33'sh00000007F;
            default: val = '0;
        endcase
        return val;
    endfunction

endpackage

// ===== sv/epq_pos_scale.sv =====
// Millimetre to metre position scaling, divide by 125 through reciprocals.
module epq_pos_scale #(
    parameter int DEPTH = epq_pkg::CORDIC_STEPS_DEF + 5
) (
    input  logic                            aclk,
    input  logic [DEPTH-1:0]                en,
    input  logic signed [epq_pkg::POS_W-1:0] mm [3],
    output logic signed [epq_pkg::POS_W-1:0] m_out [3]
);

    // Offset that makes the dividend positive: 125 * 2^32.
    localparam logic signed [40:0] BIAS = 41'sd536870912000;
    localparam logic [20:0] RECIP_HI = 21'd1073742;
    localparam logic [27:0] RECIP_LO = 28'd137438954;

    logic [19:0] a_next [3];
    logic [19:0] b_next [3];
    logic [13:0] qa_next [3];
    logic [19:0] b_reg [3];
    logic [19:0] a_reg [3];
    logic [13:0] qa0_reg [3];
    logic [13:0] qa1_reg [3];
    logic [26:0] v_next [3];
    logic [26:0] v_reg [3];
    logic [31:0] res_next [3];
    logic [31:0] res_reg [DEPTH-2][3];

    // Stage 0: split the biased dividend and divide its upper part.
    always_comb begin
        logic signed [40:0] mp;
        logic [40:0] prod_hi;
        for (int k = 0; k < 3; k++) begin
            mp = (41'(mm[k]) <<< 5) + 41'sd62 + BIAS;
            a_next[k] = mp[39:20];
            b_next[k] = mp[19:0];
            prod_hi = 41'(a_next[k]) * 41'(RECIP_HI);
            qa_next[k] = prod_hi[40:27];
        end
    end

    // Stage 1 remainder and stage 2 lower quotient.
    always_comb begin
        logic [20:0] qa_mul;
        logic [6:0]  ra;
        logic [54:0] prod_lo;
        for (int k = 0; k < 3; k++) begin
            qa_mul = 21'(qa0_reg[k]) * 21'd125;
            ra = 7'(21'(a_reg[k]) - qa_mul);
            v_next[k] = {ra, b_reg[k]};
            prod_lo = 55'(v_reg[k]) * 55'(RECIP_LO);
            res_next[k] = {qa1_reg[k][11:0], prod_lo[53:34]};
        end
    end

    // Stage registers and the delay line that aligns with the quaternion path.
    always_ff @(posedge aclk) begin
        if (en[0]) begin
            a_reg   <= a_next;
            b_reg   <= b_next;
            qa0_reg <= qa_next;
        end
        if (en[1]) begin
            v_reg   <= v_next;
            qa1_reg <= qa0_reg;
        end
        if (en[2]) begin
            res_reg[0] <= res_next;
        end
        for (int j = 1; j < DEPTH - 2; j++) begin
            if (en[j+2]) begin
                res_reg[j] <= res_reg[j-1];
            end
        end
    end

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            m_out[k] = $signed(res_reg[DEPTH-3][k]);
        end
    end

endmodule

// ===== sv/epq_angle_conv.sv =====
// Degree to radian conversion with clamping, plus the output delay line.
module epq_angle_conv #(
    parameter int DEPTH = epq_pkg::CORDIC_STEPS_DEF + 5
) (
    input  logic                             aclk,
    input  logic [DEPTH-1:0]                 en,
    input  logic signed [epq_pkg::DEG_W-1:0] deg [3],
    output logic signed [epq_pkg::RAD_W-1:0] rad_first [3],
    output logic signed [epq_pkg::RAD_W-1:0] rad_out [3]
);

    logic signed [epq_pkg::RAD_W-1:0] rad_next [3];
    logic signed [epq_pkg::RAD_W-1:0] rad_reg [DEPTH][3];

    // Clamp to one turn, multiply by pi/180 in Q0.32 and round.
    always_comb begin
        logic signed [epq_pkg::DEG_W-1:0] dc;
        logic signed [53:0] prod;
        for (int k = 0; k < 3; k++) begin
            dc = deg[k];
            if (dc > epq_pkg::DEG_LIMIT) begin
                dc = epq_pkg::DEG_LIMIT;
            end else if (dc < -epq_pkg::DEG_LIMIT) begin
                dc = -epq_pkg::DEG_LIMIT;
            end
            prod = 54'(dc) * $signed({27'd0, epq_pkg::DEG2RAD_Q32});
            prod = prod + (54'sd1 <<< 31);
            rad_next[k] = prod[51:32];
        end
    end

    // First register and the alignment delay line.
    always_ff @(posedge aclk) begin
        if (en[0]) begin
            rad_reg[0] <= rad_next;
        end
        for (int j = 1; j < DEPTH; j++) begin
            if (en[j]) begin
                rad_reg[j] <= rad_reg[j-1];
            end
        end
    end

    assign rad_first = rad_reg[0];
    assign rad_out   = rad_reg[DEPTH-1];

endmodule

// ===== sv/epq_cordic.sv =====
// Unrolled rotation-mode CORDIC giving cosine and sine of a half angle.
module epq_cordic #(
    parameter int STEPS = epq_pkg::CORDIC_STEPS_DEF
) (
    input  logic                             aclk,
    input  logic [STEPS:0]                   en,
    input  logic signed [epq_pkg::RAD_W-1:0] rad,
    output logic signed [epq_pkg::CW-1:0]    cos_out,
    output logic signed [epq_pkg::CW-1:0]    sin_out,
    output logic                             neg_out
);

    logic signed [epq_pkg::CW-1:0] x_next [STEPS+1];
    logic signed [epq_pkg::CW-1:0] y_next [STEPS+1];
    logic signed [epq_pkg::CW-1:0] z_next [STEPS+1];
    logic                          n_next [STEPS+1];
    logic signed [epq_pkg::CW-1:0] x_reg [STEPS+1];
    logic signed [epq_pkg::CW-1:0] y_reg [STEPS+1];
    logic signed [epq_pkg::CW-1:0] z_reg [STEPS+1];
    logic                          n_reg [STEPS+1];

    // Range reduction into +-pi/2, then one rotation per stage.
    always_comb begin
        logic signed [epq_pkg::CW-1:0] zin;
        zin = {rad, 13'd0};
        x_next[0] = epq_pkg::GAIN_Q30;
        y_next[0] = '0;
        if (zin > epq_pkg::HALFPI_Q30) begin
            z_next[0] = zin - epq_pkg::PI_Q30;
            n_next[0] = 1'b1;
        end else if (zin < -epq_pkg::HALFPI_Q30) begin
            z_next[0] = zin + epq_pkg::PI_Q30;
            n_next[0] = 1'b1;
        end else begin
            z_next[0] = zin;
            n_next[0] = 1'b0;
        end
        for (int i = 0; i < STEPS; i++) begin
            n_next[i+1] = n_reg[i];
            if (z_reg[i] >= 0) begin
                x_next[i+1] = x_reg[i] - (y_reg[i] >>> i);
                y_next[i+1] = y_reg[i] + (x_reg[i] >>> i);
                z_next[i+1] = z_reg[i] - epq_pkg::atan_q30(5'(i));
            end else begin
                x_next[i+1] = x_reg[i] + (y_reg[i] >>> i);
                y_next[i+1] = y_reg[i] - (x_reg[i] >>> i);
                z_next[i+1] = z_reg[i] + epq_pkg::atan_q30(5'(i));
            end
        end
    end

    // Stage registers.
    always_ff @(posedge aclk) begin
        for (int j = 0; j <= STEPS; j++) begin
            if (en[j]) begin
                x_reg[j] <= x_next[j];
                y_reg[j] <= y_next[j];
                z_reg[j] <= z_next[j];
                n_reg[j] <= n_next[j];
            end
        end
    end

    assign cos_out = x_reg[STEPS];
    assign sin_out = y_reg[STEPS];
    assign neg_out = n_reg[STEPS];

endmodule

// ===== sv/epq_quat_mix.sv =====
// Three-stage product, sum, round and saturate for the four quaternion terms.
module epq_quat_mix (
    input  logic                          aclk,
    input  logic [2:0]                    en,
    input  logic signed [epq_pkg::CW-1:0] cr, sr, cp, sp, cy, sy,
    input  logic                          neg_r, neg_p, neg_y,
    output logic signed [epq_pkg::Q_W-1:0] qw, qx, qy, qz
);

    localparam int CW = epq_pkg::CW;
    localparam int PW = 2 * CW;

    logic signed [CW-1:0] crcp_reg, srcp_reg, crsp_reg, srsp_reg, cy_reg, sy_reg;
    logic signed [CW-1:0] crcp_next, srcp_next, crsp_next, srsp_next, cy_next, sy_next;
    logic signed [PW-1:0] t_next [8];
    logic signed [PW-1:0] t_reg [8];
    logic signed [epq_pkg::Q_W-1:0] q_next [4];
    logic signed [epq_pkg::Q_W-1:0] q_reg [4];

    // Product of two Q.30 values, floored back to Q.30.
    function automatic logic signed [CW-1:0] mul30(input logic signed [CW-1:0] a,
                                                   input logic signed [CW-1:0] b);
        logic signed [PW-1:0] p;
        p = PW'(a) * PW'(b);
        return p[CW+29:30];
    endfunction

    // Sum of two Q.60 terms rounded to Q1.16 and limited to +-1.
    function automatic logic signed [epq_pkg::Q_W-1:0] to_q16(input logic signed [PW-1:0] a,
                                                              input logic signed [PW-1:0] b,
                                                              input logic sub);
        logic signed [PW:0] s;
        logic signed [PW-44:0] v;
        logic signed [epq_pkg::Q_W-1:0] r;
        s = sub ? ((PW+1)'(a) - (PW+1)'(b)) : ((PW+1)'(a) + (PW+1)'(b));
        s = s + ((PW+1)'(1) <<< 43);
        v = s[PW:44];
        if (v > (PW-43)'(epq_pkg::Q16_ONE)) begin
            r = epq_pkg::Q16_ONE;
        end else if (v < -(PW-43)'(epq_pkg::Q16_ONE)) begin
            r = -epq_pkg::Q16_ONE;
        end else begin
            r = v[epq_pkg::Q_W-1:0];
        end
        return r;
    endfunction

    // Stage 1: fold in the range reduction sign, then roll times pitch.
    always_comb begin
        logic signed [CW-1:0] cr_f, sr_f, cp_f, sp_f;
        cr_f = neg_r ? -cr : cr;
        sr_f = neg_r ? -sr : sr;
        cp_f = neg_p ? -cp : cp;
        sp_f = neg_p ? -sp : sp;
        cy_next = neg_y ? -cy : cy;
        sy_next = neg_y ? -sy : sy;
        crcp_next = mul30(cr_f, cp_f);
        srcp_next = mul30(sr_f, cp_f);
        crsp_next = mul30(cr_f, sp_f);
        srsp_next = mul30(sr_f, sp_f);
    end

    // Stage 2: multiply by the yaw factor.
    always_comb begin
        t_next[0] = PW'(crcp_reg) * PW'(cy_reg);
        t_next[1] = PW'(srsp_reg) * PW'(sy_reg);
        t_next[2] = PW'(srcp_reg) * PW'(cy_reg);
        t_next[3] = PW'(crsp_reg) * PW'(sy_reg);
        t_next[4] = PW'(crsp_reg) * PW'(cy_reg);
        t_next[5] = PW'(srcp_reg) * PW'(sy_reg);
        t_next[6] = PW'(crcp_reg) * PW'(sy_reg);
        t_next[7] = PW'(srsp_reg) * PW'(cy_reg);
    end

    // Stage 3: combine, round and saturate.
    always_comb begin
        q_next[0] = to_q16(t_reg[0], t_reg[1], 1'b0);
        q_next[1] = to_q16(t_reg[2], t_reg[3], 1'b1);
        q_next[2] = to_q16(t_reg[4], t_reg[5], 1'b0);
        q_next[3] = to_q16(t_reg[6], t_reg[7], 1'b1);
    end

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            crcp_reg <= crcp_next;
            srcp_reg <= srcp_next;
            crsp_reg <= crsp_next;
            srsp_reg <= srsp_next;
            cy_reg   <= cy_next;
            sy_reg   <= sy_next;
        end
        if (en[1]) begin
            t_reg <= t_next;
        end
        if (en[2]) begin
            q_reg <= q_next;
        end
    end

    assign qw = q_reg[0];
    assign qx = q_reg[1];
    assign qy = q_reg[2];
    assign qz = q_reg[3];

endmodule

// ===== sv/euler_pose_to_quaternion_unit.sv =====
// Top level of the pose converter: position and angle scaling plus quaternion.
//
//   channel  | direction | handshake          | payload
//   s_       | in        | s_valid / s_ready  | pos_x/y/z_mm, roll/pitch/yaw_deg
//   m_       | out       | m_valid / m_ready  | pos_x/y/z_m, roll/pitch/yaw_rad, quat_w/x/y/z
//
// One pose per cycle is accepted while s_ready is high. The pipeline has one angle
// scaling stage, one range reduction stage, one stage per CORDIC step and three
// product stages. Every stage has its own valid bit and a stage loads whenever
// it is empty or the stage after it moves, so bubbles fill up under a stall and
// the input keeps flowing while a finished beat waits, until every stage is full.
// Reset clears the valid bits only; the pipeline keeps no state between poses.
module euler_pose_to_quaternion_unit #(
    parameter int CORDIC_STEPS = epq_pkg::CORDIC_STEPS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic signed [epq_pkg::POS_W-1:0]  s_pos_x_mm,
    input  logic signed [epq_pkg::POS_W-1:0]  s_pos_y_mm,
    input  logic signed [epq_pkg::POS_W-1:0]  s_pos_z_mm,
    input  logic signed [epq_pkg::DEG_W-1:0]  s_roll_deg,
    input  logic signed [epq_pkg::DEG_W-1:0]  s_pitch_deg,
    input  logic signed [epq_pkg::DEG_W-1:0]  s_yaw_deg,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic signed [epq_pkg::POS_W-1:0]  m_pos_x_m,
    output logic signed [epq_pkg::POS_W-1:0]  m_pos_y_m,
    output logic signed [epq_pkg::POS_W-1:0]  m_pos_z_m,
    output logic signed [epq_pkg::RAD_W-1:0]  m_roll_rad,
    output logic signed [epq_pkg::RAD_W-1:0]  m_pitch_rad,
    output logic signed [epq_pkg::RAD_W-1:0]  m_yaw_rad,
    output logic signed [epq_pkg::Q_W-1:0]    m_quat_w,
    output logic signed [epq_pkg::Q_W-1:0]    m_quat_x,
    output logic signed [epq_pkg::Q_W-1:0]    m_quat_y,
    output logic signed [epq_pkg::Q_W-1:0]    m_quat_z
);

    localparam int DEPTH = CORDIC_STEPS + 5;

    logic [DEPTH-1:0] vld_reg;
    logic [DEPTH-1:0] vld_next;
    logic [DEPTH-1:0] en;

    logic signed [epq_pkg::POS_W-1:0] mm_in [3];
    logic signed [epq_pkg::POS_W-1:0] m_res [3];
    logic signed [epq_pkg::DEG_W-1:0] deg_in [3];
    logic signed [epq_pkg::RAD_W-1:0] rad_first [3];
    logic signed [epq_pkg::RAD_W-1:0] rad_res [3];
    logic signed [epq_pkg::CW-1:0]    cos_h [3];
    logic signed [epq_pkg::CW-1:0]    sin_h [3];
    logic                             neg_h [3];

    // Stage enables: a stage loads when it is empty or its successor moves.
    always_comb begin
        en[DEPTH-1] = !vld_reg[DEPTH-1] || m_ready;
        for (int k = DEPTH - 2; k >= 0; k--) begin
            en[k] = !vld_reg[k] || en[k+1];
        end
    end

    // Valid bits travel with the data.
    always_comb begin
        vld_next = vld_reg;
        if (en[0]) begin
            vld_next[0] = s_valid;
        end
        for (int k = 1; k < DEPTH; k++) begin
            if (en[k]) begin
                vld_next[k] = vld_reg[k-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    assign s_ready = en[0];
    assign m_valid = vld_reg[DEPTH-1];

    assign mm_in[0]  = s_pos_x_mm;
    assign mm_in[1]  = s_pos_y_mm;
    assign mm_in[2]  = s_pos_z_mm;
    assign deg_in[0] = s_roll_deg;
    assign deg_in[1] = s_pitch_deg;
    assign deg_in[2] = s_yaw_deg;

    // Position path.
    epq_pos_scale #(.DEPTH(DEPTH)) u_pos (
        .aclk  (aclk),
        .en    (en),
        .mm    (mm_in),
        .m_out (m_res)
    );

    // Angle path.
    epq_angle_conv #(.DEPTH(DEPTH)) u_ang (
        .aclk      (aclk),
        .en        (en),
        .deg       (deg_in),
        .rad_first (rad_first),
        .rad_out   (rad_res)
    );

    // One half-angle sine/cosine pipeline per axis.
    for (genvar a = 0; a < 3; a++) begin : g_axis
        epq_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
            .aclk    (aclk),
            .en      (en[CORDIC_STEPS+1:1]),
            .rad     (rad_first[a]),
            .cos_out (cos_h[a]),
            .sin_out (sin_h[a]),
            .neg_out (neg_h[a])
        );
    end

    // Quaternion products.
    epq_quat_mix u_quat (
        .aclk  (aclk),
        .en    (en[CORDIC_STEPS+4:CORDIC_STEPS+2]),
        .cr    (cos_h[0]),
        .sr    (sin_h[0]),
        .cp    (cos_h[1]),
        .sp    (sin_h[1]),
        .cy    (cos_h[2]),
        .sy    (sin_h[2]),
        .neg_r (neg_h[0]),
        .neg_p (neg_h[1]),
        .neg_y (neg_h[2]),
        .qw    (m_quat_w),
        .qx    (m_quat_x),
        .qy    (m_quat_y),
        .qz    (m_quat_z)
    );

    assign m_pos_x_m   = m_res[0];
    assign m_pos_y_m   = m_res[1];
    assign m_pos_z_m   = m_res[2];
    assign m_roll_rad  = rad_res[0];
    assign m_pitch_rad = rad_res[1];
    assign m_yaw_rad   = rad_res[2];

    // An empty output stage never holds back the input.
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled while the output stage is empty");

    // An accepted beat lands in the first stage.
    a_accept_lands: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> vld_reg[0])
        else $error("accepted beat lost at the first stage");

    // The w and z quaternion components stay within plus or minus one.
    a_quat_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_quat_w <= epq_pkg::Q16_ONE && m_quat_w >= -epq_pkg::Q16_ONE &&
                     m_quat_z <= epq_pkg::Q16_ONE && m_quat_z >= -epq_pkg::Q16_ONE))
        else $error("quaternion component out of range");

endmodule
